// ===== rtl/core/fmbs_pkg.sv =====
`default_nettype none

package fmbs_pkg;

    localparam int MAX_LEN     = 65536;
    localparam int ALPHABET    = 5;
    localparam int SYM_W       = 3;
    localparam int ROW_OUT_W   = 16;
    localparam int CNT_OUT_W   = 17;

    localparam int ADDR_W      = $clog2(MAX_LEN + 1);
    localparam int CNT_W       = ADDR_W;
    localparam int IVL_W       = ADDR_W + 1;
    localparam int MEM_DEPTH   = MAX_LEN + 1;
    localparam int CIDX_W      = $clog2(ALPHABET + 1);
    localparam int SIDX_W      = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

    localparam int IN_DATA_W   = ((SYM_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 2 * ROW_OUT_W + CNT_OUT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [0:0] CMD_LOAD   = 1'b0;
    localparam logic [0:0] CMD_SEARCH = 1'b1;

    localparam logic signed [IVL_W-1:0] IVL_ONE  = IVL_W'(1);
    localparam logic signed [IVL_W-1:0] IVL_ZERO = '0;

    typedef enum logic [1:0] {
        K_LOAD,
        K_SEARCH,
        K_BAD_SEARCH
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [SYM_W-1:0] sym;
        logic             last;
    } t_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_END,
        ST_NARROW,
        ST_REPORT
    } t_state;

    typedef logic [ALPHABET-1:0][CNT_W-1:0] t_occ_row;

endpackage

`default_nettype wire

// ===== rtl/core/fmbs_front.sv =====
`default_nettype none

module fmbs_front (
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [fmbs_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic [0:0]                    i_s_axis_tuser,
    input  wire logic                          i_s_axis_tlast,
    input  wire logic                          i_q_full,
    output logic                               o_q_push,
    output fmbs_pkg::t_item                    o_q_item
);
    import fmbs_pkg::*;

    logic [SYM_W-1:0] sym;
    logic             sym_ok;
    logic             keep;

    assign sym    = i_s_axis_tdata[SYM_W-1:0];
    assign sym_ok = sym inside {[SYM_W'(1):SYM_W'(ALPHABET)]};

    // bad-code loads are dropped here; everything else goes to the back end
    assign keep = (i_s_axis_tuser == CMD_SEARCH) || sym_ok;

    assign o_s_axis_tready = !i_q_full;
    assign o_q_push        = i_s_axis_tvalid && !i_q_full && keep;

    always_comb begin
        o_q_item.sym  = sym;
        o_q_item.last = i_s_axis_tlast;
        if (i_s_axis_tuser == CMD_LOAD) begin
            o_q_item.kind = K_LOAD;
        end else if (sym_ok) begin
            o_q_item.kind = K_SEARCH;
        end else begin
            o_q_item.kind = K_BAD_SEARCH;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fmbs_queue.sv =====
`default_nettype none

module fmbs_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fmbs_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output fmbs_pkg::t_item      o_item
);
    import fmbs_pkg::*;

    t_item             r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fmbs_back.sv =====
`default_nettype none

module fmbs_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_q_valid,
    input  wire fmbs_pkg::t_item                i_q_item,
    output logic                                o_q_pop,
    output logic                                o_m_valid,
    input  wire logic                           i_m_ready,
    output logic                                o_found,
    output logic [fmbs_pkg::ROW_OUT_W-1:0]      o_first_row,
    output logic [fmbs_pkg::ROW_OUT_W-1:0]      o_last_row,
    output logic [fmbs_pkg::CNT_OUT_W-1:0]      o_match_count
);
    import fmbs_pkg::*;

    function automatic logic [ADDR_W-1:0] clamp_row(
        input logic signed [IVL_W-1:0] row,
        input logic [ADDR_W-1:0]       len
    );
        if (row > $signed({1'b0, len})) begin
            return len;
        end
        return row[ADDR_W-1:0];
    endfunction

    function automatic logic signed [IVL_W-1:0] ext(input logic [CNT_W-1:0] v);
        return $signed({1'b0, v});
    endfunction

    t_state                  r_state, n_state;
    logic [ADDR_W-1:0]       r_len;
    t_occ_row                r_tot, n_tot;
    logic [CNT_W-1:0]        r_cum [ALPHABET + 1];
    logic                    r_active;
    logic signed [IVL_W-1:0] r_start, r_end;
    logic [SYM_W-1:0]        r_sym;
    logic                    r_last;
    logic [ADDR_W-1:0]       r_re;
    logic                    r_zero_s, r_zero_e;
    logic [CNT_W-1:0]        r_occ_s;
    t_occ_row                r_occ_mem [MEM_DEPTH];
    t_occ_row                r_rd_data;

    logic                    r_o_valid;
    logic                    r_o_found;
    logic [ROW_OUT_W-1:0]    r_o_first, r_o_last;
    logic [CNT_OUT_W-1:0]    r_o_count;

    logic                    out_free;
    logic                    is_load, can_load, wr_en, nonempty, narrow;
    logic [CIDX_W-1:0]       q_cidx, r_cidx;
    logic [SIDX_W-1:0]       q_sidx, r_sidx;
    logic [ADDR_W-1:0]       start_row, end_row, rd_addr, wr_addr;
    logic [CNT_W-1:0]        occ_e;
    logic signed [IVL_W-1:0] res_span;

    assign out_free  = !r_o_valid || i_m_ready;
    assign is_load   = (i_q_item.kind == K_LOAD);
    assign can_load  = (r_len < ADDR_W'(MAX_LEN));
    assign nonempty  = (r_start <= r_end);
    assign narrow    = r_active && nonempty && (i_q_item.kind == K_SEARCH);
    assign q_cidx    = CIDX_W'(i_q_item.sym);
    assign r_cidx    = CIDX_W'(r_sym);
    assign q_sidx    = SIDX_W'(i_q_item.sym - SYM_W'(1));
    assign r_sidx    = SIDX_W'(r_sym - SYM_W'(1));
    assign start_row = clamp_row(r_start, r_len);
    assign end_row   = clamp_row(r_end + IVL_ONE, r_len);
    assign wr_addr   = r_len + 1'b1;
    assign occ_e     = r_zero_e ? '0 : r_rd_data[r_sidx];
    assign res_span  = r_end - r_start + IVL_ONE;

    always_comb begin
        n_tot         = r_tot;
        n_tot[q_sidx] = r_tot[q_sidx] + 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && !is_load) begin
                    if (narrow) begin
                        n_state = ST_READ_END;
                    end else if (i_q_item.last) begin
                        n_state = ST_REPORT;
                    end
                end
            end
            ST_READ_END: n_state = ST_NARROW;
            ST_NARROW:   n_state = r_last ? ST_REPORT : ST_IDLE;
            ST_REPORT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop = 1'b0;
        wr_en   = 1'b0;
        rd_addr = start_row;
        case (r_state)
            ST_IDLE: begin
                o_q_pop = i_q_valid;
                wr_en   = i_q_valid && is_load && can_load;
            end
            ST_READ_END: rd_addr = r_re;
            default: begin
                rd_addr = start_row;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_occ_mem[wr_addr] <= n_tot;
        end
        r_rd_data <= r_occ_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= '0;
            r_tot     <= '0;
            r_active  <= 1'b0;
            r_start   <= '0;
            r_end     <= '0;
            r_o_valid <= 1'b0;
            for (int j = 0; j <= ALPHABET; j++) begin
                r_cum[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_REPORT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_o_valid <= 1'b0;
            end
            if (wr_en) begin
                r_len <= r_len + 1'b1;
                r_tot <= n_tot;
                for (int j = 1; j <= ALPHABET; j++) begin
                    if (CIDX_W'(j) >= q_cidx) begin
                        r_cum[j] <= r_cum[j] + 1'b1;
                    end
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid && !is_load) begin
                        if (!r_active) begin
                            r_active <= 1'b1;
                            if (i_q_item.kind == K_SEARCH) begin
                                r_start <= ext(r_cum[q_cidx - CIDX_W'(1)]);
                                r_end   <= ext(r_cum[q_cidx]) - IVL_ONE;
                            end else begin
                                r_start <= IVL_ONE;
                                r_end   <= IVL_ZERO;
                            end
                        end else if (nonempty && !narrow) begin
                            r_start <= IVL_ONE;
                            r_end   <= IVL_ZERO;
                        end
                    end
                end
                ST_NARROW: begin
                    r_start <= ext(r_cum[r_cidx - CIDX_W'(1)]) + ext(r_occ_s);
                    r_end   <= ext(r_cum[r_cidx - CIDX_W'(1)]) + ext(occ_e) - IVL_ONE;
                end
                ST_REPORT: begin
                    if (out_free) begin
                        r_active <= 1'b0;
                    end
                end
                default: begin
                    r_active <= r_active;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && narrow) begin
            r_sym    <= i_q_item.sym;
            r_last   <= i_q_item.last;
            r_re     <= end_row;
            r_zero_s <= (start_row == '0);
            r_zero_e <= (end_row == '0);
        end
        if (r_state == ST_READ_END) begin
            r_occ_s <= r_zero_s ? '0 : r_rd_data[r_sidx];
        end
        if (r_state == ST_REPORT && out_free) begin
            r_o_found <= nonempty;
            r_o_first <= nonempty ? r_start[ROW_OUT_W-1:0] : '0;
            r_o_last  <= nonempty ? r_end[ROW_OUT_W-1:0] : '0;
            r_o_count <= nonempty ? res_span[CNT_OUT_W-1:0] : '0;
        end
    end

    assign o_m_valid     = r_o_valid;
    assign o_found       = r_o_found;
    assign o_first_row   = r_o_first;
    assign o_last_row    = r_o_last;
    assign o_match_count = r_o_count;

endmodule

`default_nettype wire

// ===== rtl/core/fm_index_backward_search.sv =====
// FM-index backward search. Load transfers (tuser = 0) with a valid code
// append one BWT symbol each, up to MAX_LEN; search transfers (tuser = 1)
// give pattern symbols last-to-first, tlast on the pattern's first symbol,
// which yields one result transfer. A narrowing symbol passes READ_END and
// NARROW, since both occurrence lookups go one after the other through the
// single read port of the occurrence memory; a final symbol then passes
// REPORT to register the result. A four-entry queue sits between the input
// and the search engine. No clearing pass is needed after reset.
`default_nettype none

module fm_index_backward_search (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // symbol
    input  wire logic [fmbs_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // command
    input  wire logic [0:0]                       i_s_axis_tuser,
    input  wire logic                             i_s_axis_tlast,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // first_row, last_row, match_count
    output logic [fmbs_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    // found
    output logic [0:0]                            o_m_axis_tuser
);
    import fmbs_pkg::*;

    logic                 q_push, q_full, q_pop, q_valid;
    t_item                push_item, head_item;
    logic                 found;
    logic [ROW_OUT_W-1:0] first_row, last_row;
    logic [CNT_OUT_W-1:0] match_count;

    fmbs_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_item        (push_item)
    );

    fmbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    fmbs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (head_item),
        .o_q_pop       (q_pop),
        .o_m_valid     (o_m_axis_tvalid),
        .i_m_ready     (i_m_axis_tready),
        .o_found       (found),
        .o_first_row   (first_row),
        .o_last_row    (last_row),
        .o_match_count (match_count)
    );

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, match_count, last_row, first_row};
    assign o_m_axis_tuser = found;

endmodule

`default_nettype wire

// ===== rtl/core/fmbs_checker.sv =====
`default_nettype none

module fmbs_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_m_axis_tvalid,
    input wire logic                             i_m_axis_tready,
    input wire logic [fmbs_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input wire logic [0:0]                       o_m_axis_tuser
);
    import fmbs_pkg::*;

    logic [ROW_OUT_W-1:0] first_row, last_row;
    logic [CNT_OUT_W-1:0] match_count;

    assign first_row   = o_m_axis_tdata[ROW_OUT_W-1:0];
    assign last_row    = o_m_axis_tdata[2*ROW_OUT_W-1:ROW_OUT_W];
    assign match_count = o_m_axis_tdata[OUT_FIELD_W-1:2*ROW_OUT_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("miss carries nonzero data");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            (last_row >= first_row) &&
            (match_count == CNT_OUT_W'(last_row) - CNT_OUT_W'(first_row) + 1'b1))
        else $error("hit count does not match interval");

endmodule

bind fm_index_backward_search fmbs_checker u_fmbs_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    import fmbs_pkg::*;

    localparam int NSYM        = ALPHABET;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 480;

    typedef struct packed {
        logic                 found;
        logic [ROW_OUT_W-1:0] lo_row;
        logic [ROW_OUT_W-1:0] hi_row;
        logic [CNT_OUT_W-1:0] match_count;
    } t_search_result;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data  = '0;     // symbol
    logic [0:0]            s_user  = CMD_LOAD; // command
    logic                  s_last  = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;           // first_row, last_row, match_count
    logic [0:0]            m_user;           // found

    // occurrence rows and per-code totals of the loaded BWT
    bit [CNT_OUT_W-1:0] occ_rows [0:MAX_LEN][1:NSYM];
    int unsigned        code_total [1:NSYM];
    int unsigned        loaded_len;
    longint             ivl_lo;
    longint             ivl_hi;
    bit                 query_open;

    t_search_result pending_results[$];
    int             err_count     = 0;
    int             items_sent    = 0;
    bit             src_idle      = 1'b1;
    bit             sink_idle     = 1'b1;
    int             sink_hold_req = 0;

    fm_index_backward_search i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic int draw_gap(bit enabled);
        return enabled ? $urandom_range(0, 14) : 0;
    endfunction

    function automatic longint code_offset(int code);
        longint sum;
        sum = 0;
        for (int k = 1; k < code && k <= NSYM; k++) begin
            sum += code_total[k];
        end
        return sum;
    endfunction

    function automatic longint occ_count(int code, longint row);
        if (row < 0) begin
            return 0;
        end
        if (row > loaded_len) begin
            row = loaded_len;
        end
        return occ_rows[row][code];
    endfunction

    function automatic void search_track(logic [0:0] cmd, logic [2:0] sym, logic is_last);
        bit             sym_ok;
        longint         base;
        longint         nxt_lo;
        longint         nxt_hi;
        t_search_result res;
        sym_ok = (sym >= 1) && (sym <= NSYM);
        if (cmd == CMD_LOAD) begin
            if (sym_ok && loaded_len < MAX_LEN) begin
                for (int k = 1; k <= NSYM; k++) begin
                    occ_rows[loaded_len + 1][k] = occ_rows[loaded_len][k];
                end
                occ_rows[loaded_len + 1][sym] += 1;
                code_total[sym] += 1;
                loaded_len += 1;
            end
            return;
        end
        if (!query_open) begin
            query_open = 1'b1;
            if (sym_ok) begin
                ivl_lo = code_offset(sym);
                ivl_hi = code_offset(sym + 1) - 1;
            end else begin
                ivl_lo = 1;
                ivl_hi = 0;
            end
        end else if (ivl_lo <= ivl_hi) begin
            if (sym_ok) begin
                base   = code_offset(sym);
                nxt_lo = base + occ_count(sym, ivl_lo);
                nxt_hi = base + occ_count(sym, ivl_hi + 1) - 1;
                ivl_lo = nxt_lo;
                ivl_hi = nxt_hi;
            end else begin
                ivl_lo = 1;
                ivl_hi = 0;
            end
        end
        if (!is_last) begin
            return;
        end
        query_open = 1'b0;
        res = '0;
        if (ivl_lo <= ivl_hi) begin
            res.found       = 1'b1;
            res.lo_row      = ivl_lo[ROW_OUT_W-1:0];
            res.hi_row      = ivl_hi[ROW_OUT_W-1:0];
            res.match_count = CNT_OUT_W'(ivl_hi - ivl_lo + 1);
        end
        pending_results.push_back(res);
    endfunction

    // picks a code that keeps the current interval non-empty, if one exists
    function automatic logic [2:0] live_symbol();
        int     cands[$];
        longint lo;
        longint hi;
        for (int c = 1; c <= NSYM; c++) begin
            if (!query_open) begin
                lo = code_offset(c);
                hi = code_offset(c + 1) - 1;
            end else begin
                lo = code_offset(c) + occ_count(c, ivl_lo);
                hi = code_offset(c) + occ_count(c, ivl_hi + 1) - 1;
            end
            if (lo <= hi) begin
                cands.push_back(c);
            end
        end
        if (cands.size() == 0) begin
            return 3'($urandom_range(1, NSYM));
        end
        return 3'(cands[$urandom_range(0, cands.size() - 1)]);
    endfunction

    function automatic logic [2:0] draw_symbol(int bad_pct);
        if ($urandom_range(0, 99) < bad_pct) begin
            case ($urandom_range(0, 2))
                0:       return 3'd0;
                1:       return 3'd6;
                default: return 3'd7;
            endcase
        end
        return 3'($urandom_range(1, NSYM));
    endfunction

    task automatic send_item(input logic [0:0] cmd, input logic [2:0] sym, input logic is_last);
        int gap;
        gap = draw_gap(src_idle);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= IN_DATA_W'(sym);
        s_last  <= is_last;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        search_track(cmd, sym, is_last);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic run_query(int len, int live_pct, int bad_pct, int load_pct);
        logic [2:0] sym;
        for (int i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(0, 99) < load_pct) begin
                send_item(CMD_LOAD, draw_symbol(5), 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 99) < live_pct) begin
                sym = live_symbol();
            end else begin
                sym = draw_symbol(bad_pct);
            end
            send_item(CMD_SEARCH, sym, i == len - 1);
        end
    endtask

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            err_count++;
        end
    endtask

    // result checker
    initial begin
        t_search_result want;
        forever begin
            @(posedge clk);
            if (rst_n && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, actual %h/%h",
                             $time, m_user, m_data);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("found", want.found, m_user[0]);
                    check_field("first_row", want.lo_row, m_data[15:0]);
                    check_field("last_row", want.hi_row, m_data[31:16]);
                    check_field("match_count", want.match_count, m_data[48:32]);
                end
            end
        end
    end

    // result receiver: per-transfer stalls plus an optional long hold-off
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge clk);
            if (sink_hold_req > 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (m_valid && m_ready) begin
                stall_left = draw_gap(sink_idle);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    task automatic test_directed();
        // empty index: nothing can match
        send_item(CMD_SEARCH, 3'd1, 1'b1);
        // bad codes and last flag on loads are ignored
        send_item(CMD_LOAD, 3'd0, 1'b0);
        send_item(CMD_LOAD, 3'd7, 1'b1);
        send_item(CMD_LOAD, 3'd3, 1'b1);
        send_item(CMD_LOAD, 3'd2, 1'b0);
        send_item(CMD_LOAD, 3'd1, 1'b0);
        send_item(CMD_LOAD, 3'd4, 1'b0);
        send_item(CMD_LOAD, 3'd5, 1'b0);
        send_item(CMD_LOAD, 3'd2, 1'b0);
        send_item(CMD_LOAD, 3'd3, 1'b0);
        // sentinel matches at row zero; top code at the high end
        send_item(CMD_SEARCH, 3'd1, 1'b1);
        send_item(CMD_SEARCH, 3'd5, 1'b1);
        send_item(CMD_SEARCH, 3'd2, 1'b0);
        send_item(CMD_SEARCH, 3'd3, 1'b1);
        // bad search code first, then as the final symbol
        send_item(CMD_SEARCH, 3'd6, 1'b0);
        send_item(CMD_SEARCH, 3'd2, 1'b1);
        send_item(CMD_SEARCH, 3'd3, 1'b0);
        send_item(CMD_SEARCH, 3'd0, 1'b1);
        // interval goes empty, later symbols ignored
        send_item(CMD_SEARCH, 3'd5, 1'b0);
        send_item(CMD_SEARCH, 3'd5, 1'b0);
        send_item(CMD_SEARCH, 3'd4, 1'b1);
        // load in the middle of a query
        send_item(CMD_SEARCH, 3'd2, 1'b0);
        send_item(CMD_LOAD, 3'd4, 1'b0);
        send_item(CMD_SEARCH, 3'd4, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_random_traffic();
        int start_cnt;
        int pick;
        start_cnt = items_sent;
        while (items_sent - start_cnt < RANDOM_ITEMS) begin
            case (((items_sent - start_cnt) / 70) % 4)
                0:       begin src_idle = 1'b1; sink_idle = 1'b1; end
                1:       begin src_idle = 1'b0; sink_idle = 1'b1; end
                2:       begin src_idle = 1'b1; sink_idle = 1'b0; end
                default: begin src_idle = 1'b0; sink_idle = 1'b0; end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                repeat ($urandom_range(1, 12)) begin
                    send_item(CMD_LOAD, draw_symbol(5), 1'($urandom_range(0, 1)));
                end
            end else if (pick < 32) begin
                run_query($urandom_range(1, 4), 0, 30, 10);
            end else begin
                run_query($urandom_range(1, 6), 80, 3, 8);
            end
        end
        wait_for_drain();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        src_idle      = 1'b0;
        sink_hold_req = 300;
        repeat (24) run_query($urandom_range(1, 2), 90, 0, 0);
        wait_for_drain();
        src_idle = 1'b1;
        repeat (8) run_query($urandom_range(1, 3), 90, 0, 0);
        wait_for_drain();
    endtask

    task automatic test_every_code();
        src_idle = 1'b1;
        for (int c = 1; c <= NSYM; c++) begin
            send_item(CMD_SEARCH, 3'(c), 1'b1);
        end
        repeat (20) run_query($urandom_range(1, 8), 85, 2, 5);
        wait_for_drain();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic();
        test_backpressure();
        test_every_code();
        wait_for_drain();
        repeat (40) @(posedge clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
